@@ hw/rtl/mvm_pkg.sv @@
// package: sizes, codes, state type and control structs of the matrix-vector multiplier
`timescale 1ns / 1ps
package mvm_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int ADDR_W     = $clog2(MAX_COLS);
    localparam int COL_W      = $clog2(MAX_COLS + 1);
    localparam int NCOLS_W    = 11;
    localparam int CNT_W      = (COL_W > NCOLS_W) ? COL_W : NCOLS_W;
    localparam int ROW_W      = 16;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = 48;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load_we;
        logic mat_start;
        logic mul_en;
        logic acc_en;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic row_end;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/mvm_in_if.sv @@
// input channel: vector or matrix element beats
`timescale 1ns / 1ps
interface mvm_in_if;
    import mvm_pkg::*;

    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

@@ hw/rtl/mvm_out_if.sv @@
// output channel: one row sum beat per matrix row
`timescale 1ns / 1ps
interface mvm_out_if;
    import mvm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SUM_W-1:0]  row_sum;
    logic [ROW_W-1:0]  row_index;
    logic              last_row;

    modport source (output valid, output row_sum, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_sum, input row_index, input last_row,
                    output ready);
endinterface

@@ hw/rtl/mvm_ctrl.sv @@
// controller: sequences one beat at a time; a matrix beat goes through read, multiply and accumulate
`timescale 1ns / 1ps
module mvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mvm_pkg::t_cmd     i_in_command,
    input  mvm_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output mvm_pkg::t_dp_cmd  o_cmd
);
    import mvm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_command == CMD_MATRIX) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!i_sts.row_end || i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_we   = w_accept && i_in_command == CMD_LOAD;
                o_cmd.mat_start = w_accept && i_in_command == CMD_MATRIX;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
            end
            ST_ACC: begin
                o_cmd.acc_en = !i_sts.row_end;
                o_cmd.emit   = i_sts.row_end && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/mvm_dp.sv @@
// datapath: config registers, vector memory, multiplier, accumulator and output register
`timescale 1ns / 1ps
module mvm_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  mvm_pkg::t_cfg_idx             i_cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mvm_pkg::VAL_W-1:0]     i_value,
    input  mvm_pkg::t_dp_cmd              i_cmd,
    output mvm_pkg::t_dp_sts              o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mvm_pkg::SUM_W-1:0]     o_row_sum,
    output logic [mvm_pkg::ROW_W-1:0]     o_row_index,
    output logic                          o_last_row
);
    import mvm_pkg::*;

    logic [VAL_W-1:0]   r_mem [MAX_COLS];
    logic [ROW_W-1:0]   r_num_rows;
    logic [NCOLS_W-1:0] r_num_cols;
    logic [ADDR_W-1:0]  r_load_pos;
    logic [ADDR_W-1:0]  r_col_pos;
    logic [ROW_W-1:0]   r_row_pos;
    logic [SUM_W-1:0]   r_sum;
    logic [VAL_W-1:0]   r_rd;
    logic [VAL_W-1:0]   r_val;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_last;

    logic [CNT_W-1:0]   w_cols;
    logic [ROW_W:0]     w_rows;
    logic [CNT_W:0]     w_load_next;
    logic [CNT_W:0]     w_col_next;
    logic [ROW_W:0]     w_row_next;
    logic               w_row_last;
    logic [SUM_W-1:0]   w_sum;

    always_comb begin
        if (r_num_cols == '0) begin
            w_cols = CNT_W'(1);
        end else if (CNT_W'(r_num_cols) > CNT_W'(MAX_COLS)) begin
            w_cols = CNT_W'(MAX_COLS);
        end else begin
            w_cols = CNT_W'(r_num_cols);
        end
    end

    assign w_rows      = (r_num_rows == '0) ? (ROW_W+1)'(1) : {1'b0, r_num_rows};
    assign w_load_next = (CNT_W+1)'(r_load_pos) + (CNT_W+1)'(1);
    assign w_col_next  = (CNT_W+1)'(r_col_pos) + (CNT_W+1)'(1);
    assign w_row_next  = {1'b0, r_row_pos} + (ROW_W+1)'(1);
    assign w_row_last  = w_row_next >= w_rows;
    assign w_sum       = r_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    assign o_sts.row_end  = w_col_next >= {1'b0, w_cols};
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // vector memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[r_load_pos] <= i_value;
        end
        if (i_cmd.mat_start) begin
            r_rd  <= r_mem[r_col_pos];
            r_val <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'($signed(r_rd) * $signed(r_val));
        end
        if (i_cmd.emit) begin
            r_out_sum  <= w_sum;
            r_out_row  <= r_row_pos;
            r_out_last <= w_row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= ROW_W'(1);
            r_num_cols  <= NCOLS_W'(1);
            r_load_pos  <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data[ROW_W-1:0];
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data[NCOLS_W-1:0];
                    default: begin
                        r_num_rows <= r_num_rows;
                    end
                endcase
            end
            if (i_cmd.load_we) begin
                r_load_pos <= (w_load_next >= {1'b0, w_cols}) ? '0 : w_load_next[ADDR_W-1:0];
            end
            if (i_cmd.acc_en) begin
                r_sum     <= w_sum;
                r_col_pos <= w_col_next[ADDR_W-1:0];
            end
            if (i_cmd.emit) begin
                r_sum     <= '0;
                r_col_pos <= '0;
                r_row_pos <= w_row_last ? '0 : w_row_next[ROW_W-1:0];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_sum   = r_out_sum;
    assign o_row_index = r_out_row;
    assign o_last_row  = r_out_last;

endmodule

@@ hw/rtl/matrix_vector_multiply_top.sv @@
// top level: streaming matrix-vector product y = A*x with Q8.8 operands
// vector beat: written straight into the vector memory
// matrix beat: memory read, multiply, accumulate in turn; the row sum goes to the output
//   register after the last beat of a row, and the input stays closed until the beat is accumulated
// the registered memory read and the multiplier register lie between a matrix beat and its accumulate step
// reset clears the positions, the row sum and the output valid; vector memory is not cleared
`timescale 1ns / 1ps
module matrix_vector_multiply_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mvm_in_if.sink                         i_in,
    mvm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  mvm_pkg::t_cfg_idx              i_cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mvm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mvm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .i_sts        (w_sts),
        .o_in_ready   (i_in.ready),
        .o_cmd        (w_cmd)
    );

    mvm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_in.value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_row_sum   (o_out.row_sum),
        .o_row_index (o_out.row_index),
        .o_last_row  (o_out.last_row)
    );

endmodule

@@ hw/rtl/mvm_checker.sv @@
// checker: port-level timing properties of the matrix-vector multiplier
`timescale 1ns / 1ps
module mvm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input mvm_pkg::t_cmd i_in_command,
    input logic          i_out_valid,
    input logic          i_out_ready
);
    import mvm_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // a matrix beat keeps the input closed while it is worked on
    a_mat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_MATRIX |=> !i_in_ready)
        else $error("input open during matrix beat");

    // no result appears the cycle right after any accepted beat
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result too early");

    // a new result only follows a busy cycle
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without accumulate step");

endmodule

bind matrix_vector_multiply_top mvm_checker u_mvm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready)
);

@@ dv/mvm_row_sum_checker.sv @@
// checker: predicts each row sum of the matrix-vector product and compares the output beats
`timescale 1ns / 1ps
module mvm_row_sum_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mvm_in_if                              i_in_mon,
    mvm_out_if                             i_out_mon,
    input  logic                           i_cfg_we,
    input  mvm_pkg::t_cfg_idx              i_cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_rows_pending
);
    import mvm_pkg::*;

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0] row_index;
        logic             last_row;
    } t_row_result;

    logic [VAL_W-1:0]   vector_mem [MAX_COLS];
    int                 load_ptr;
    int                 col_ptr;
    int                 row_ptr;
    logic [SUM_W-1:0]   row_acc;
    logic [ROW_W-1:0]   rows_reg;
    logic [NCOLS_W-1:0] cols_reg;
    t_row_result        expected_rows [$];

    task automatic accumulate_beat(input t_cmd cmd, input logic [VAL_W-1:0] val);
        int                        n;
        int                        rows;
        int                        col;
        logic signed [PROD_W-1:0]  prod;
        t_row_result               res;
        n = (cols_reg == '0) ? 1 : ((int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg));
        rows = (rows_reg == '0) ? 1 : int'(rows_reg);
        if (cmd == CMD_LOAD) begin
            if (load_ptr >= MAX_COLS) begin
                load_ptr = 0;
            end
            vector_mem[load_ptr] = val;
            load_ptr = (load_ptr + 1 >= n) ? 0 : load_ptr + 1;
        end else begin
            col = (col_ptr >= MAX_COLS) ? 0 : col_ptr;
            prod = $signed(vector_mem[col]) * $signed(val);
            row_acc = row_acc + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
            if (col_ptr + 1 < n) begin
                col_ptr++;
            end else begin
                res.row_sum   = row_acc;
                res.row_index = row_ptr[ROW_W-1:0];
                res.last_row  = (row_ptr + 1 >= rows);
                expected_rows.push_back(res);
                col_ptr = 0;
                row_acc = '0;
                row_ptr = res.last_row ? 0 : row_ptr + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_row_result exp_row;
        if (!i_rst_n) begin
            rows_reg     = ROW_W'(1);
            cols_reg     = NCOLS_W'(1);
            load_ptr     = 0;
            col_ptr      = 0;
            row_ptr      = 0;
            row_acc      = '0;
            o_mismatches = 0;
            expected_rows.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_rows.size() == 0) begin
                    $error("row_sum beat with no row pending: row_sum %h row_index %0d",
                           i_out_mon.row_sum, i_out_mon.row_index);
                    o_mismatches++;
                end else begin
                    exp_row = expected_rows.pop_front();
                    if (i_out_mon.row_sum !== exp_row.row_sum) begin
                        $error("row_sum expected %h actual %h",
                               exp_row.row_sum, i_out_mon.row_sum);
                        o_mismatches++;
                    end
                    if (i_out_mon.row_index !== exp_row.row_index) begin
                        $error("row_index expected %0d actual %0d",
                               exp_row.row_index, i_out_mon.row_index);
                        o_mismatches++;
                    end
                    if (i_out_mon.last_row !== exp_row.last_row) begin
                        $error("last_row expected %b actual %b",
                               exp_row.last_row, i_out_mon.last_row);
                        o_mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS: begin
                        rows_reg = i_cfg_data[ROW_W-1:0];
                    end
                    CFG_NUM_COLS: begin
                        cols_reg = i_cfg_data[NCOLS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                accumulate_beat(i_in_mon.command, i_in_mon.value);
            end
        end
        o_rows_pending = expected_rows.size();
    end

endmodule

@@ dv/tb_matrix_vector_multiply_top.sv @@
// testbench top: stimulus, handshake pressure and verdict for the matrix-vector multiplier
`timescale 1ns / 1ps
module tb_matrix_vector_multiply_top;
    import mvm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int ITEM_TARGET  = 1850;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int rows_pending;
    int cycle_count;
    int beats_sent;
    int burst_left;

    // stream positions, tracked only to keep matrix beats on loaded vector entries
    int vec_load_ptr;
    int vec_col_ptr;
    int vec_len;
    bit vec_loaded [MAX_COLS];

    mvm_in_if  in_ch ();
    mvm_out_if out_ch ();

    matrix_vector_multiply_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mvm_row_sum_checker u_row_sum_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_rows_pending (rows_pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int cols_in_effect(input int cols);
        return (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            4: v = 16'h0001;
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        do @(negedge clk); while (rows_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int rows, input logic [CFG_DATA_W-1:0] cols_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= cols_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        vec_len = cols_in_effect(int'(cols_word[NCOLS_W-1:0]));
    endtask

    task automatic send_beat(input t_cmd cmd, input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value   <= val;
        do @(posedge clk); while (!in_ch.ready);
        beats_sent++;
        if (cmd == CMD_LOAD) begin
            if (vec_load_ptr >= MAX_COLS) begin
                vec_load_ptr = 0;
            end
            vec_loaded[vec_load_ptr] = 1'b1;
            vec_load_ptr = (vec_load_ptr + 1 >= vec_len) ? 0 : vec_load_ptr + 1;
        end else begin
            vec_col_ptr = (vec_col_ptr + 1 < vec_len) ? vec_col_ptr + 1 : 0;
        end
    endtask

    task automatic run_phase();
        int                    rows;
        int                    cols;
        int                    n;
        int                    nload;
        int                    nmat;
        logic [CFG_DATA_W-1:0] cols_word;
        t_cmd                  cmd;
        case ($urandom_range(0, 7))
            0: rows = 0;
            1: rows = 65535;
            default: rows = $urandom_range(1, 6);
        endcase
        if ($urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 3))
                0: cols = MAX_COLS;
                1: cols = 2047;
                2: cols = $urandom_range(MAX_COLS + 1, 2047);
                default: cols = $urandom_range(33, MAX_COLS - 1);
            endcase
        end else if ($urandom_range(0, 9) == 0) begin
            cols = 0;
        end else begin
            cols = $urandom_range(1, 8);
        end
        n = cols_in_effect(cols);
        // a row left open on an unloaded entry must stay inside the row
        if (!vec_loaded[vec_col_ptr] && n <= vec_col_ptr) begin
            cols = vec_col_ptr + 1;
            n = cols;
        end
        cols_word = CFG_DATA_W'(cols);
        if ($urandom_range(0, 3) == 0) begin
            cols_word[CFG_DATA_W-1:NCOLS_W] = (CFG_DATA_W-NCOLS_W)'($urandom_range(0, 31));
        end
        wait_idle();
        set_size(rows, cols_word);
        nload = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
        nmat = n * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) begin
            nmat += $urandom_range(0, n - 1);
        end
        if (n > 32) begin
            if (nload > 100) nload = 100;
            if (nmat > 40) nmat = 40;
        end
        for (int k = 0; k < nload + nmat; k++) begin
            cmd = (k < nload) ? CMD_LOAD : CMD_MATRIX;
            if ($urandom_range(0, 11) == 0) begin
                cmd = t_cmd'($urandom_range(0, 1));
            end
            if (cmd == CMD_MATRIX && !vec_loaded[vec_col_ptr]) begin
                cmd = CMD_LOAD;
            end
            send_beat(cmd, random_value());
        end
        in_ch.valid <= 1'b0;
    endtask

    // receiver stall pattern
    initial begin
        int mode;
        int span;
        int k;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 60);
            for (k = 0; k < span; k++) begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 5) == 0);
                    default: out_ch.ready <= ((k % 4) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_matrix_vector_multiply_top NOT OK");
        $finish;
    end

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_LOAD;
        in_ch.value   <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_NUM_ROWS;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        beats_sent   = 0;
        burst_left   = 0;
        vec_load_ptr = 0;
        vec_col_ptr  = 0;
        vec_len      = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // zero sizes act as one, operand extremes
        set_size(0, 16'd0);
        send_beat(CMD_LOAD, 16'h7FFF);
        send_beat(CMD_MATRIX, 16'h7FFF);
        send_beat(CMD_MATRIX, 16'h8000);
        send_beat(CMD_LOAD, 16'h8000);
        send_beat(CMD_MATRIX, 16'h8000);
        send_beat(CMD_MATRIX, 16'h0000);
        send_beat(CMD_MATRIX, 16'h0001);
        in_ch.valid <= 1'b0;

        // load wrap, load in the middle of a row
        wait_idle();
        set_size(2, 16'd3);
        send_beat(CMD_LOAD, 16'hFFFF);
        send_beat(CMD_LOAD, 16'h7FFF);
        send_beat(CMD_LOAD, 16'h8000);
        send_beat(CMD_LOAD, 16'h0005);
        send_beat(CMD_MATRIX, 16'h7FFF);
        send_beat(CMD_MATRIX, 16'h8000);
        send_beat(CMD_LOAD, 16'hFFFF);
        send_beat(CMD_MATRIX, 16'h0001);
        send_beat(CMD_MATRIX, 16'h8000);
        send_beat(CMD_MATRIX, 16'h8000);
        in_ch.valid <= 1'b0;

        // shrink mid-row and mid-product: open column and row count as ends
        wait_idle();
        set_size(1, 16'd2);
        send_beat(CMD_MATRIX, 16'h7FFF);
        in_ch.valid <= 1'b0;

        // largest row count, column count above the maximum with upper data bits set
        wait_idle();
        set_size(65535, 16'hFFFF);
        send_beat(CMD_MATRIX, 16'h7FFF);
        send_beat(CMD_MATRIX, 16'hFFFF);
        send_beat(CMD_MATRIX, 16'h0064);
        in_ch.valid <= 1'b0;

        while (beats_sent < ITEM_TARGET) begin
            run_phase();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("tb_matrix_vector_multiply_top OK");
        end else begin
            $display("tb_matrix_vector_multiply_top NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_in_if.sv
hw/rtl/mvm_out_if.sv
hw/rtl/mvm_ctrl.sv
hw/rtl/mvm_dp.sv
hw/rtl/matrix_vector_multiply_top.sv
hw/rtl/mvm_checker.sv
dv/mvm_row_sum_checker.sv
dv/tb_matrix_vector_multiply_top.sv
